### rtl/mcod_pkg.sv
package mcod_pkg;

   localparam int MaxMatricesDef = 16;
   localparam int DimBitsDef     = 12;
   localparam int CostW          = 40;
   localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

   localparam logic [1:0] ErrNone     = 2'd0;
   localparam logic [1:0] ErrTooFew   = 2'd1;
   localparam logic [1:0] ErrTooMany  = 2'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_FILL_START,
      ST_K_READ,
      ST_K_WAIT,
      ST_K_EVAL,
      ST_K_MUL2,
      ST_K_CMP,
      ST_CELL_WRITE,
      ST_WALK_INIT,
      ST_WALK_POP,
      ST_WALK_READ,
      ST_WALK_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_dim;
      logic clear_load;
      logic diag_init;
      logic cell_begin;
      logic k_read;
      logic k_eval;
      logic k_mul2;
      logic k_cmp;
      logic cell_write;
      logic next_cell;
      logic walk_init;
      logic walk_pop;
      logic walk_read;
      logic walk_emit;
      logic emit_error;
      logic emit_single;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic overflow;
      logic too_few;
      logic single;
      logic diag_done;
      logic k_last;
      logic fill_done;
      logic stack_empty;
      logic seg_trivial;
   } status_type;

endpackage

### rtl/mcod_ctrl.sv
module mcod_ctrl
   import mcod_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_dim_final,
   input  status_type stat,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_dim = 1'b1;
               if (req_dim_final) begin
                  state_in = ST_FILL_START;
               end
            end
         end
         ST_FILL_START: begin
            cmd.clear_load = 1'b1;
            priority if (stat.overflow || stat.too_few) begin
               cmd.emit_error = 1'b1;
               state_in       = ST_LOAD;
            end else if (stat.single) begin
               cmd.emit_single = 1'b1;
               state_in        = ST_LOAD;
            end else begin
               cmd.diag_init = 1'b1;
               if (stat.diag_done) begin
                  cmd.cell_begin = 1'b1;
                  state_in       = ST_K_READ;
               end
            end
         end
         ST_K_READ: begin
            cmd.k_read = 1'b1;
            state_in   = ST_K_WAIT;
         end
         ST_K_WAIT: begin
            state_in = ST_K_EVAL;
         end
         ST_K_EVAL: begin
            cmd.k_eval = 1'b1;
            state_in   = ST_K_MUL2;
         end
         ST_K_MUL2: begin
            cmd.k_mul2 = 1'b1;
            state_in   = ST_K_CMP;
         end
         ST_K_CMP: begin
            cmd.k_cmp = 1'b1;
            state_in  = stat.k_last ? ST_CELL_WRITE : ST_K_READ;
         end
         ST_CELL_WRITE: begin
            cmd.cell_write = 1'b1;
            if (stat.fill_done) begin
               state_in = ST_WALK_INIT;
            end else begin
               cmd.next_cell = 1'b1;
               state_in      = ST_K_READ;
            end
         end
         ST_WALK_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_WALK_POP;
         end
         ST_WALK_POP: begin
            if (stat.stack_empty) begin
               state_in = ST_LOAD;
            end else begin
               cmd.walk_pop = 1'b1;
               state_in     = ST_WALK_READ;
            end
         end
         ST_WALK_READ: begin
            if (stat.seg_trivial) begin
               state_in = ST_WALK_POP;
            end else begin
               cmd.walk_read = 1'b1;
               state_in      = ST_WALK_EMIT;
            end
         end
         ST_WALK_EMIT: begin
            cmd.walk_emit = 1'b1;
            state_in      = ST_WALK_POP;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

### rtl/mcod_datapath.sv
module mcod_datapath
   import mcod_pkg::*;
#(
   parameter int MAX_MATRICES = MaxMatricesDef,
   parameter int DIM_BITS     = DimBitsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [11:0]       req_dim_value,
   output status_type        stat,
   output logic              rsp_valid,
   output logic [CostW-1:0]  rsp_total_cost,
   output logic [4:0]        rsp_seg_first,
   output logic [4:0]        rsp_seg_end,
   output logic [3:0]        rsp_split_point,
   output logic              rsp_has_split,
   output logic [1:0]        rsp_error_code,
   output logic              rsp_run_end
);

   localparam int Side   = MAX_MATRICES + 1;
   localparam int IdxW   = $clog2(Side + 1);
   localparam int AW     = $clog2(Side);
   localparam int TabD   = Side * Side;
   localparam int TabW   = $clog2(TabD);
   localparam int StackW = $clog2(Side + 1);

   // dimension list, cost and split tables, walk stack
   logic [DIM_BITS-1:0] dims_mem [Side];
   logic [CostW-1:0]    cost_mem [TabD];
   logic [AW-1:0]       split_mem [TabD];
   logic [2*AW-1:0]     stack_mem [Side];

   logic [IdxW-1:0]   count_ff;
   logic              overflow_ff;
   logic [IdxW-1:0]   nmat;
   logic [AW-1:0]     len_ff, i_ff, k_ff, diag_ff;
   logic [AW-1:0]     j;
   logic [CostW-1:0]  best_ff, cik_ff, ckj_ff, cand_ff, prod_ff, root_cost_ff;
   logic [DIM_BITS-1:0] da_ff, db_ff, dc_ff;
   logic [2*DIM_BITS-1:0] ab_ff;
   logic [AW-1:0]     bk_ff;
   logic              have_ff;
   logic [StackW-1:0] sp_ff;
   logic [AW-1:0]     wi_ff, wj_ff;
   logic [AW-1:0]     rk_ff;

   function automatic logic [TabW-1:0] tab_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
      logic [2*AW+1:0] a;
      a = (2*AW+2)'(r) * (2*AW+2)'(Side) + (2*AW+2)'(c);
      return TabW'(a);
   endfunction

   assign nmat = count_ff - IdxW'(1);
   assign j    = AW'(i_ff + len_ff - AW'(1));

   assign stat.overflow    = overflow_ff;
   assign stat.too_few     = (count_ff < IdxW'(2));
   assign stat.single      = (count_ff == IdxW'(2));
   assign stat.diag_done   = (IdxW'(diag_ff) == nmat);
   assign stat.k_last      = (AW'(k_ff + AW'(1)) == j);
   assign stat.fill_done   = (IdxW'(len_ff) == nmat) && (i_ff == AW'(1));
   assign stat.stack_empty = (sp_ff == '0);
   assign stat.seg_trivial = (wi_ff >= wj_ff);

   // dimension load
   always_ff @(posedge clock) begin
      if (cmd.load_dim && count_ff < IdxW'(Side)) begin
         dims_mem[AW'(count_ff)] <= DIM_BITS'(req_dim_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_load && !cmd.diag_init) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.load_dim) begin
         if (count_ff < IdxW'(Side)) count_ff <= count_ff + IdxW'(1);
         else                         overflow_ff <= 1'b1;
      end else if (cmd.walk_init) begin
         count_ff <= '0;
      end
   end

   // diagonal clear, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset || cmd.walk_init) begin
         diag_ff <= AW'(1);
      end else if (cmd.diag_init && !stat.diag_done) begin
         diag_ff <= diag_ff + AW'(1);
      end
   end

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.diag_init) begin
         cost_mem[tab_addr(diag_ff, diag_ff)] <= '0;
      end else if (cmd.cell_write) begin
         cost_mem[tab_addr(i_ff, j)]  <= best_ff;
         split_mem[tab_addr(i_ff, j)] <= bk_ff;
      end
      cik_ff <= cost_mem[tab_addr(i_ff, k_ff)];
      ckj_ff <= cost_mem[tab_addr(AW'(k_ff + AW'(1)), j)];
      if (cmd.walk_read) rk_ff <= split_mem[tab_addr(wi_ff, wj_ff)];
   end

   // cell and split scan indices
   always_ff @(posedge clock) begin
      if (cmd.cell_begin) begin
         len_ff  <= AW'(2);
         i_ff    <= AW'(1);
         k_ff    <= AW'(1);
         have_ff <= 1'b0;
      end else if (cmd.k_cmp && !stat.k_last) begin
         k_ff <= k_ff + AW'(1);
      end else if (cmd.next_cell) begin
         have_ff <= 1'b0;
         if (IdxW'(j) == nmat) begin
            len_ff <= len_ff + AW'(1);
            i_ff   <= AW'(1);
            k_ff   <= AW'(1);
         end else begin
            i_ff <= i_ff + AW'(1);
            k_ff <= i_ff + AW'(1);
         end
      end
      if (cmd.k_cmp) have_ff <= 1'b1;
   end

   // candidate cost: saturating sum of the two subcosts, saturating product, then their saturating sum
   always_ff @(posedge clock) begin
      logic [CostW:0]           s1;
      logic [CostW:0]           s2;
      logic [3*DIM_BITS-1:0]    abc;
      if (cmd.k_read) begin
         da_ff <= dims_mem[AW'(i_ff - AW'(1))];
         db_ff <= dims_mem[k_ff];
         dc_ff <= dims_mem[j];
      end
      if (cmd.k_eval) begin
         ab_ff <= da_ff * db_ff;
         s1 = {1'b0, cik_ff} + {1'b0, ckj_ff};
         cand_ff <= s1[CostW] ? CostMax : s1[CostW-1:0];
      end
      if (cmd.k_mul2) begin
         abc = (3*DIM_BITS)'(ab_ff) * (3*DIM_BITS)'(dc_ff);
         if ((3*DIM_BITS) > CostW && (abc >> CostW) != '0) prod_ff <= CostMax;
         else                                                 prod_ff <= CostW'(abc);
      end
      if (cmd.k_cmp) begin
         s2 = {1'b0, cand_ff} + {1'b0, prod_ff};
         if (!have_ff || (s2[CostW] ? CostMax : s2[CostW-1:0]) < best_ff) begin
            best_ff <= s2[CostW] ? CostMax : s2[CostW-1:0];
            bk_ff   <= k_ff;
         end
      end
   end

   // preorder walk over the split tree
   always_ff @(posedge clock) begin
      logic [StackW-1:0] sp_n;
      if (reset) begin
         sp_ff <= '0;
      end else if (cmd.walk_init) begin
         stack_mem[0] <= {AW'(1), AW'(nmat)};
         sp_ff        <= StackW'(1);
         // the last cell written is the whole chain
         root_cost_ff <= best_ff;
      end else if (cmd.walk_pop) begin
         {wi_ff, wj_ff} <= stack_mem[AW'(sp_ff - StackW'(1))];
         sp_ff          <= sp_ff - StackW'(1);
      end else if (cmd.walk_emit) begin
         sp_n = sp_ff;
         if (AW'(rk_ff + AW'(1)) < wj_ff && sp_n < StackW'(Side)) begin
            stack_mem[AW'(sp_n)] <= {AW'(rk_ff + AW'(1)), wj_ff};
            sp_n = sp_n + StackW'(1);
         end
         if (wi_ff < rk_ff && sp_n < StackW'(Side)) begin
            stack_mem[AW'(sp_n)] <= {wi_ff, rk_ff};
            sp_n = sp_n + StackW'(1);
         end
         sp_ff <= sp_n;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      logic last;
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.walk_emit || cmd.emit_error || cmd.emit_single;
      end
      last = !(AW'(rk_ff + AW'(1)) < wj_ff) && !(wi_ff < rk_ff) && (sp_ff == '0);
      if (cmd.emit_error) begin
         rsp_total_cost  <= '0;
         rsp_seg_first   <= '0;
         rsp_seg_end     <= '0;
         rsp_split_point <= '0;
         rsp_has_split   <= 1'b0;
         rsp_error_code  <= overflow_ff ? ErrTooMany : ErrTooFew;
         rsp_run_end     <= 1'b1;
      end else if (cmd.emit_single) begin
         rsp_total_cost  <= '0;
         rsp_seg_first   <= 5'd1;
         rsp_seg_end     <= 5'd1;
         rsp_split_point <= '0;
         rsp_has_split   <= 1'b0;
         rsp_error_code  <= ErrNone;
         rsp_run_end     <= 1'b1;
      end else begin
         rsp_total_cost  <= root_cost_ff;
         rsp_seg_first   <= 5'(wi_ff);
         rsp_seg_end     <= 5'(wj_ff);
         rsp_split_point <= 4'(rk_ff);
         rsp_has_split   <= 1'b1;
         rsp_error_code  <= ErrNone;
         rsp_run_end     <= last;
      end
   end

endmodule

### rtl/matrix_chain_order_dp.sv
// load takes one dimension item per cycle while busy is low; after the final
// item each split candidate of the fill passes read, wait, eval, mul2 and cmp
// states, set by the shared table read and two-step saturating multiply; each
// preorder walk result passes pop, read, emit; results arrive one strobe each.
// busy stays high from the final item until the last result; reset is
// synchronous, active high, and returns the block to loading with no results.
module matrix_chain_order_dp
   import mcod_pkg::*;
#(
   parameter int MAX_MATRICES = MaxMatricesDef,
   parameter int DIM_BITS     = DimBitsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [11:0]      req_dim_value,
   input  logic             req_dim_final,
   output logic             rsp_valid,
   output logic [39:0]      rsp_total_cost,
   output logic [4:0]       rsp_seg_first,
   output logic [4:0]       rsp_seg_end,
   output logic [3:0]       rsp_split_point,
   output logic             rsp_has_split,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_run_end
);

   cmd_type    cmd;
   status_type stat;

   mcod_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_dim_final (req_dim_final),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   mcod_datapath #(
      .MAX_MATRICES (MAX_MATRICES),
      .DIM_BITS     (DIM_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_dim_value   (req_dim_value),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_seg_first   (rsp_seg_first),
      .rsp_seg_end     (rsp_seg_end),
      .rsp_split_point (rsp_split_point),
      .rsp_has_split   (rsp_has_split),
      .rsp_error_code  (rsp_error_code),
      .rsp_run_end     (rsp_run_end)
   );

endmodule

### rtl/mcod_checker.sv
module mcod_checker
   import mcod_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_dim_final,
   input logic        rsp_valid,
   input logic        rsp_has_split,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_run_end
);

   // an error result is always the last of its chain
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ErrNone |-> rsp_run_end && !rsp_has_split)
      else $error("error result not marked as last");

   // a final item makes the block busy
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_dim_final |=> busy)
      else $error("not busy after final item");

   // after the last result the block is idle in the same or the next cycle
   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |-> ##[0:1] !busy)
      else $error("busy after last result");

   // no results while loading, other than a last one
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) && !$past(reset) |-> !rsp_valid || rsp_run_end)
      else $error("result while loading");

endmodule

bind matrix_chain_order_dp mcod_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_dim_final  (req_dim_final),
   .rsp_valid      (rsp_valid),
   .rsp_has_split  (rsp_has_split),
   .rsp_error_code (rsp_error_code),
   .rsp_run_end    (rsp_run_end)
);

### test/chain_order_checker.sv
`timescale 1ns / 100ps

module chain_order_checker
   import mcod_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [11:0] req_dim_value,
   input  logic        req_dim_final,
   input  logic        rsp_valid,
   input  logic [39:0] rsp_total_cost,
   input  logic [4:0]  rsp_seg_first,
   input  logic [4:0]  rsp_seg_end,
   input  logic [3:0]  rsp_split_point,
   input  logic        rsp_has_split,
   input  logic [1:0]  rsp_error_code,
   input  logic        rsp_run_end,
   output int          mismatch_count,
   output int          splits_pending
);

   localparam int Side = MaxMatricesDef + 1;

   typedef struct packed {
      logic [39:0] cost;
      logic [4:0]  seg_lo;
      logic [4:0]  seg_hi;
      logic [3:0]  split;
      logic        has;
      logic [1:0]  err;
      logic        last;
   } split_node_t;

   split_node_t split_queue[$];

   // model state
   logic [11:0] chain_dims[Side];
   int          dims_loaded;
   logic        dims_dropped;

   function automatic logic [39:0] cost_add(logic [39:0] a, logic [39:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[40] ? CostMax : s[39:0];
   endfunction

   // collect one dimension, and on the final one solve the chain
   task automatic absorb_dim(logic [11:0] value, logic fin);
      logic [39:0] best_cost[Side][Side];
      int          best_split[Side][Side];
      int          lo_stack[Side];
      int          hi_stack[Side];
      int          n, cnt, i, j, k, depth;
      logic [39:0] cand, best, prod;
      split_node_t node;
      if (dims_loaded < Side) begin
         chain_dims[dims_loaded] = value;
         dims_loaded++;
      end else begin
         dims_dropped = 1'b1;
      end
      if (!fin) return;
      cnt = dims_loaded;
      dims_loaded = 0;
      node = '0;
      node.last = 1'b1;
      if (dims_dropped) begin
         dims_dropped = 1'b0;
         node.err = ErrTooMany;
         split_queue.push_back(node);
         return;
      end
      if (cnt < 2) begin
         node.err = ErrTooFew;
         split_queue.push_back(node);
         return;
      end
      n = cnt - 1;
      if (n == 1) begin
         node.seg_lo = 5'd1;
         node.seg_hi = 5'd1;
         split_queue.push_back(node);
         return;
      end
      // bottom-up fill by subchain length, leftmost split wins ties
      for (i = 1; i <= n; i++) best_cost[i][i] = '0;
      for (int len = 2; len <= n; len++) begin
         for (i = 1; i + len - 1 <= n; i++) begin
            j = i + len - 1;
            best = '0;
            for (k = i; k < j; k++) begin
               prod = 40'(chain_dims[i-1]) * 40'(chain_dims[k]) * 40'(chain_dims[j]);
               cand = cost_add(cost_add(best_cost[i][k], best_cost[k+1][j]), prod);
               if (k == i || cand < best) begin
                  best = cand;
                  best_split[i][j] = k;
               end
            end
            best_cost[i][j] = best;
         end
      end
      // preorder walk of the split tree
      depth = 1;
      lo_stack[0] = 1;
      hi_stack[0] = n;
      while (depth > 0) begin
         depth--;
         i = lo_stack[depth];
         j = hi_stack[depth];
         if (i < j) begin
            k = best_split[i][j];
            node.cost = best_cost[1][n];
            node.seg_lo = 5'(i);
            node.seg_hi = 5'(j);
            node.split = 4'(k);
            node.has = 1'b1;
            node.err = ErrNone;
            node.last = 1'b0;
            split_queue.push_back(node);
            if (k + 1 < j) begin
               lo_stack[depth] = k + 1;
               hi_stack[depth] = j;
               depth++;
            end
            if (i < k) begin
               lo_stack[depth] = i;
               hi_stack[depth] = k;
               depth++;
            end
         end
      end
      split_queue[split_queue.size()-1].last = 1'b1;
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin
      split_node_t seen, want;
      if (reset) begin
         dims_loaded = 0;
         dims_dropped = 1'b0;
         split_queue.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            seen = '{rsp_total_cost, rsp_seg_first, rsp_seg_end, rsp_split_point,
                     rsp_has_split, rsp_error_code, rsp_run_end};
            if (split_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t unexpected result %p", $realtime, seen);
            end else begin
               want = split_queue.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t mismatch: expected %p, got %p", $realtime, want, seen);
               end
            end
         end
         if (start && !busy)
            absorb_dim(req_dim_value, req_dim_final);
      end
      splits_pending = split_queue.size();
   end

   initial begin
      mismatch_count = 0;
      splits_pending = 0;
   end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mcod_pkg::*;

   localparam int ItemTarget = 380;
   localparam int StallLimit = 60000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_dim_value;
   logic        req_dim_final;
   logic        rsp_valid;
   logic [39:0] rsp_total_cost;
   logic [4:0]  rsp_seg_first;
   logic [4:0]  rsp_seg_end;
   logic [3:0]  rsp_split_point;
   logic        rsp_has_split;
   logic [1:0]  rsp_error_code;
   logic        rsp_run_end;
   int          mismatch_count;
   int          splits_pending;
   int          items_sent;
   int          idle_pct;
   int          stall_cycles;

   matrix_chain_order_dp dut (.*);

   chain_order_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // offer one item and hold it until accepted; called at a falling edge
   task automatic send_dim(logic [11:0] value, logic fin);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_dim_value <= value;
      req_dim_final <= fin;
      while (busy) @(negedge clock);
      @(negedge clock);
      items_sent++;
      if (items_sent < ItemTarget / 3) idle_pct = 9;
      else if (items_sent < 2 * ItemTarget / 3) idle_pct = 84;
      else idle_pct = 0;
   endtask

   // one chain of ndims dimensions; mode 0 random, 1 small values, 2 all max, 3 all zero
   task automatic send_chain(int ndims, int mode);
      logic [11:0] v;
      for (int d = 0; d < ndims; d++) begin
         case (mode)
            0: v = 12'($urandom_range(4095));
            1: v = 12'($urandom_range(9));
            2: v = 12'hfff;
            default: v = 12'h000;
         endcase
         send_dim(v, d == ndims - 1);
      end
   endtask

   initial begin
      int ndims, pick;
      reset = 1'b1;
      start = 1'b0;
      req_dim_value = '0;
      req_dim_final = 1'b0;
      items_sent = 0;
      idle_pct = 9;
      stall_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single matrix, too few, largest values, ties, small values, overflow
      send_chain(2, 0);
      send_chain(1, 0);
      send_chain(5, 2);
      send_chain(3, 3);
      send_chain(4, 1);
      send_chain(19, 0);

      // hold off until the block has drained
      start <= 1'b0;
      while (splits_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      // random chains, mostly short
      while (items_sent < ItemTarget) begin
         pick = $urandom_range(99);
         if (pick < 5) ndims = 1;
         else if (pick < 10) ndims = $urandom_range(20, 18);
         else if (pick < 20) ndims = $urandom_range(17, 9);
         else ndims = $urandom_range(8, 2);
         send_chain(ndims, $urandom_range(1));
      end
      start <= 1'b0;

      while (splits_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatch_count == 0 && splits_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
